@@ hw/rtl/zbuffer_torus_point_shader_assert.svh @@
// assertion macros for the torus point shader checker
// no dependencies; included by the checker module only
`ifndef ZBUFFER_TORUS_POINT_SHADER_ASSERT_SVH
`define ZBUFFER_TORUS_POINT_SHADER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zts assertion failed");

// antecedent implies consequent in the next cycle
`define ZTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zts assertion failed");

`endif

@@ hw/rtl/zts_pkg.sv @@
// shared types, codes and constants for the torus point shader
// no dependencies; imported by the sequencer, the datapath and the top level
package zts_pkg;

    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 58;
    localparam int COORD_FRAC = 38;
    localparam int DEPTH_W    = 16;
    localparam int SHADE_W    = 4;
    localparam int WORD_W     = DEPTH_W + SHADE_W;
    localparam int DIV_STEPS  = 17;
    localparam int QUO_W      = DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0]   DIV_REM_INIT = MUL_W'(8192);
    localparam logic [MUL_W-1:0]   Z_SAT_LIMIT  = MUL_W'(16384);
    localparam logic [SHADE_W-1:0] BLANK_SHADE  = 4'd12;
    localparam logic [SHADE_W-1:0] SHADE_MAX    = 4'd11;
    localparam logic [WORD_W-1:0]  CLEAR_WORD   = {{DEPTH_W{1'b0}}, BLANK_SHADE};
    localparam logic [6:0]         GLYPH_SPACE  = 7'h20;

    localparam logic [2:0] CFG_COS_ROT_A   = 3'd0;
    localparam logic [2:0] CFG_SIN_ROT_A   = 3'd1;
    localparam logic [2:0] CFG_COS_ROT_B   = 3'd2;
    localparam logic [2:0] CFG_SIN_ROT_B   = 3'd3;
    localparam logic [2:0] CFG_TUBE_RADIUS = 3'd4;
    localparam logic [2:0] CFG_RING_RADIUS = 3'd5;
    localparam logic [2:0] CFG_VIEW_DIST   = 3'd6;
    localparam logic [2:0] CFG_PROJ_SCALE  = 3'd7;

    // one multiply per micro-op, in issue order
    typedef enum logic [5:0] {
        M_NONE, M_CX, M_CY, M_CBCP, M_SASB, M_SASB_SP, M_CASB, M_X1, M_X2,
        M_SBCP, M_SACB, M_SACB_SP, M_CACB, M_Y1, M_Y2, M_CACX, M_Z1, M_Z2,
        M_CPCT, M_L1, M_CACT, M_L2, M_L3, M_CAST, M_CTSA, M_CTSA_SP, M_L4,
        M_SCALE, M_PX_LO, M_PX_HI, M_PY_LO, M_PY_HI, M_ADDR, M_RADDR
    } t_mop;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OP, S_ZCHK, S_DIV, S_COLCHK, S_ROWCHK, S_RD, S_RDW, S_OUT
    } t_state;

    typedef struct packed {
        t_mop mop;
        logic capture;
        logic div_init;
        logic div_step;
        logic col_chk;
        logic row_chk;
        logic ram_rd;
        logic ram_wr_plot;
        logic ram_wr_clr;
        logic out_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic z_pos;
        logic z_small;
        logic coord_ok;
        logic lum_pos;
        logic nearer;
        logic in_grid;
        logic out_free;
    } t_sts;

    function automatic logic [6:0] glyph_of(input logic [SHADE_W-1:0] shade);
        logic [6:0] g;
        case (shade)
            4'd0:    g = 7'h2E;
            4'd1:    g = 7'h2C;
            4'd2:    g = 7'h2D;
            4'd3:    g = 7'h7E;
            4'd4:    g = 7'h3A;
            4'd5:    g = 7'h3B;
            4'd6:    g = 7'h3D;
            4'd7:    g = 7'h21;
            4'd8:    g = 7'h2A;
            4'd9:    g = 7'h23;
            4'd10:   g = 7'h24;
            4'd11:   g = 7'h40;
            default: g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

endpackage

@@ hw/rtl/zts_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module zts_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1760
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/zts_ctrl.sv @@
// sequencer for the torus point shader: clear pass, micro-op issue, divide, store update
// depends on zts_pkg
module zts_ctrl
    import zts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_kind,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    t_mop              r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= M_NONE;
            r_cnt   <= '0;
            r_kind  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.mop = M_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_kind  = i_kind;
                    n_state = S_OP;
                    n_op    = i_kind ? M_RADDR : M_CX;
                end
            end
            S_OP: begin
                o_cmd.mop = r_op;
                case (r_op)
                    M_L4:            n_state = S_ZCHK;
                    M_PX_HI:         n_state = S_COLCHK;
                    M_PY_HI:         n_state = S_ROWCHK;
                    M_ADDR, M_RADDR: n_state = S_RD;
                    default:         n_op = t_mop'(r_op + 6'd1);
                endcase
            end
            S_ZCHK: begin
                if (!i_sts.z_pos) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = '0;
                    if (i_sts.z_small) begin
                        n_state = S_OP;
                        n_op    = M_SCALE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_OP;
                    n_op    = M_SCALE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_COLCHK: begin
                o_cmd.col_chk = 1'b1;
                if (i_sts.coord_ok) begin
                    n_state = S_OP;
                    n_op    = M_PY_LO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROWCHK: begin
                o_cmd.row_chk = 1'b1;
                if (i_sts.coord_ok && i_sts.lum_pos) begin
                    n_state = S_OP;
                    n_op    = M_ADDR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (r_kind && !i_sts.in_grid) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state = S_RDW;
                end
            end
            S_RDW: begin
                if (r_kind) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.ram_wr_plot = i_sts.nearer;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.ram_wr_clr = i_sts.in_grid;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hw/rtl/zts_dp.sv @@
// datapath: config registers, shared multiplier, divider, projection, depth store
// depends on zts_pkg and zts_ram
module zts_dp
    import zts_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [15:0] i_cos_tube,
    input  logic signed [15:0] i_sin_tube,
    input  logic signed [15:0] i_cos_ring,
    input  logic signed [15:0] i_sin_ring,
    input  logic [6:0]         i_column,
    input  logic [4:0]         i_line,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [6:0]         o_glyph
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int FL_W  = ACC_W - COORD_FRAC;
    localparam logic signed [ACC_W-1:0] COL_BASE = ACC_W'(COLUMNS / 2) <<< COORD_FRAC;
    localparam logic signed [ACC_W-1:0] ROW_BASE = ACC_W'(ROWS / 2) <<< COORD_FRAC;

    // configuration
    logic signed [15:0] r_cos_a, r_sin_a, r_cos_b, r_sin_b;
    logic [9:0]         r_tube_r, r_ring_r;
    logic [11:0]        r_view;
    logic [15:0]        r_proj;

    // captured transaction
    logic signed [15:0] r_ct, r_st, r_cp, r_sp;
    logic [6:0]         r_in_col;
    logic [4:0]         r_in_line;

    // working registers
    logic signed [MUL_W-1:0] r_cx, r_cy, r_ta, r_tb, r_tc, r_x, r_y, r_z, r_lum;
    logic [31:0]             r_scale;
    logic signed [ACC_W-1:0] r_acc;
    logic [MUL_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [CW-1:0]           r_col;
    logic [RW-1:0]           r_row;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_out_valid;
    logic [6:0]              r_glyph;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  sh14, sh8;
    logic [DEPTH_W-1:0]       ooz;
    logic [MUL_W-1:0]         rem_dbl;
    logic                     rem_ge;
    logic signed [FL_W-1:0]   fl;
    logic                     frac_nz;
    logic                     coord_in;
    logic [11:0]              lum_hi;
    logic [SHADE_W-1:0]       shade;
    logic                     in_grid;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [WORD_W-1:0]        ram_wdata;
    logic [WORD_W-1:0]        ram_rdata;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mop)
            M_CX:      begin op_a = $signed(MUL_W'(r_tube_r)); op_b = MUL_W'(r_ct); end
            M_CY:      begin op_a = $signed(MUL_W'(r_tube_r)); op_b = MUL_W'(r_st); end
            M_CBCP:    begin op_a = MUL_W'(r_cos_b); op_b = MUL_W'(r_cp); end
            M_SASB:    begin op_a = MUL_W'(r_sin_a); op_b = MUL_W'(r_sin_b); end
            M_SASB_SP: begin op_a = r_tb; op_b = MUL_W'(r_sp); end
            M_CASB:    begin op_a = MUL_W'(r_cos_a); op_b = MUL_W'(r_sin_b); end
            M_X1:      begin op_a = r_cx; op_b = r_ta + r_tb; end
            M_X2:      begin op_a = r_cy; op_b = r_tc; end
            M_SBCP:    begin op_a = MUL_W'(r_sin_b); op_b = MUL_W'(r_cp); end
            M_SACB:    begin op_a = MUL_W'(r_sin_a); op_b = MUL_W'(r_cos_b); end
            M_SACB_SP: begin op_a = r_tb; op_b = MUL_W'(r_sp); end
            M_CACB:    begin op_a = MUL_W'(r_cos_a); op_b = MUL_W'(r_cos_b); end
            M_Y1:      begin op_a = r_cx; op_b = r_ta - r_tb; end
            M_Y2:      begin op_a = r_cy; op_b = r_tc; end
            M_CACX:    begin op_a = MUL_W'(r_cos_a); op_b = r_cx; end
            M_Z1:      begin op_a = r_ta; op_b = MUL_W'(r_sp); end
            M_Z2:      begin op_a = r_cy; op_b = MUL_W'(r_sin_a); end
            M_CPCT:    begin op_a = MUL_W'(r_cp); op_b = MUL_W'(r_ct); end
            M_L1:      begin op_a = r_ta; op_b = MUL_W'(r_sin_b); end
            M_CACT:    begin op_a = MUL_W'(r_cos_a); op_b = MUL_W'(r_ct); end
            M_L2:      begin op_a = r_ta; op_b = MUL_W'(r_sp); end
            M_L3:      begin op_a = MUL_W'(r_sin_a); op_b = MUL_W'(r_st); end
            M_CAST:    begin op_a = MUL_W'(r_cos_a); op_b = MUL_W'(r_st); end
            M_CTSA:    begin op_a = MUL_W'(r_ct); op_b = MUL_W'(r_sin_a); end
            M_CTSA_SP: begin op_a = r_tb; op_b = MUL_W'(r_sp); end
            M_L4:      begin op_a = MUL_W'(r_cos_b); op_b = r_ta - r_tb; end
            M_SCALE:   begin op_a = $signed(MUL_W'(r_proj)); op_b = $signed(MUL_W'(ooz)); end
            M_PX_LO:   begin op_a = $signed(MUL_W'(r_scale[15:0])); op_b = r_x; end
            M_PX_HI:   begin op_a = $signed(MUL_W'(r_scale[31:16])); op_b = r_x; end
            M_PY_LO:   begin op_a = $signed(MUL_W'(r_scale[15:0])); op_b = -r_y; end
            M_PY_HI:   begin op_a = $signed(MUL_W'(r_scale[31:16])); op_b = -r_y; end
            M_ADDR:    begin op_a = $signed(MUL_W'(r_row)); op_b = MUL_W'(COLUMNS); end
            M_RADDR:   begin op_a = $signed(MUL_W'(r_in_line)); op_b = MUL_W'(COLUMNS); end
            default:   begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;
    assign sh14 = MUL_W'(prod >>> 14);
    assign sh8  = MUL_W'(prod >>> 8);

    // reciprocal of depth, saturated where depth is one or below
    assign ooz     = (r_z < $signed(Z_SAT_LIMIT) || r_quo[QUO_W-1]) ? '1 : r_quo[DEPTH_W-1:0];
    assign rem_dbl = {r_rem[MUL_W-2:0], 1'b0};
    assign rem_ge  = rem_dbl >= $unsigned(r_z);

    // cell coordinate: integer part and truncation toward zero
    assign fl       = r_acc[ACC_W-1:COORD_FRAC];
    assign frac_nz  = |r_acc[COORD_FRAC-1:0];
    assign coord_in = i_cmd.row_chk ? (fl < $signed(FL_W'(ROWS)))
                                    : (fl < $signed(FL_W'(COLUMNS)));

    assign lum_hi  = r_lum[MUL_W-2:11];
    assign shade   = (lum_hi > 12'(SHADE_MAX)) ? SHADE_MAX : lum_hi[SHADE_W-1:0];
    assign in_grid = (9'(r_in_col) < 9'(COLUMNS)) && (9'(r_in_line) < 9'(ROWS));

    always_comb begin
        o_sts            = '0;
        o_sts.clear_last = (r_clr_addr == AW'(CELLS - 1));
        o_sts.z_pos      = r_z > 0;
        o_sts.z_small    = r_z < $signed(Z_SAT_LIMIT);
        o_sts.coord_ok   = (!fl[FL_W-1] && coord_in) || (fl == -1 && frac_nz);
        o_sts.lum_pos    = r_lum > 0;
        o_sts.nearer     = ooz > ram_rdata[WORD_W-1:SHADE_W];
        o_sts.in_grid    = in_grid;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_a     <= 16'sd16384;
            r_sin_a     <= '0;
            r_cos_b     <= 16'sd16384;
            r_sin_b     <= '0;
            r_tube_r    <= 10'd256;
            r_ring_r    <= 10'd512;
            r_view      <= 12'd1280;
            r_proj      <= 16'd12800;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COS_ROT_A:   r_cos_a  <= i_cfg_data;
                    CFG_SIN_ROT_A:   r_sin_a  <= i_cfg_data;
                    CFG_COS_ROT_B:   r_cos_b  <= i_cfg_data;
                    CFG_SIN_ROT_B:   r_sin_b  <= i_cfg_data;
                    CFG_TUBE_RADIUS: r_tube_r <= i_cfg_data[9:0];
                    CFG_RING_RADIUS: r_ring_r <= i_cfg_data[9:0];
                    CFG_VIEW_DIST:   r_view   <= i_cfg_data[11:0];
                    CFG_PROJ_SCALE:  r_proj   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ct      <= i_cos_tube;
            r_st      <= i_sin_tube;
            r_cp      <= i_cos_ring;
            r_sp      <= i_sin_ring;
            r_in_col  <= i_column;
            r_in_line <= i_line;
        end
        if (i_cmd.div_init) begin
            r_rem <= DIV_REM_INIT;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_dbl - $unsigned(r_z) : rem_dbl;
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
        end
        if (i_cmd.col_chk) r_col <= fl[FL_W-1] ? '0 : fl[CW-1:0];
        if (i_cmd.row_chk) r_row <= fl[FL_W-1] ? '0 : fl[RW-1:0];
        if (i_cmd.out_load) r_glyph <= in_grid ? glyph_of(ram_rdata[SHADE_W-1:0]) : GLYPH_SPACE;
        case (i_cmd.mop)
            M_CX:      r_cx <= sh8 + $signed(MUL_W'({r_ring_r, 6'b0}));
            M_CY:      r_cy <= sh8;
            M_CBCP, M_SBCP, M_CACX, M_CPCT, M_CACT, M_CAST:
                       r_ta <= sh14;
            M_SASB, M_SASB_SP, M_SACB, M_SACB_SP, M_CTSA, M_CTSA_SP:
                       r_tb <= sh14;
            M_CASB, M_CACB:
                       r_tc <= sh14;
            M_X1:      r_x <= sh14;
            M_X2:      r_x <= r_x - sh14;
            M_Y1:      r_y <= sh14;
            M_Y2:      r_y <= r_y + sh14;
            M_Z1:      r_z <= $signed(MUL_W'({r_view, 6'b0})) + sh14;
            M_Z2:      r_z <= r_z + sh14;
            M_L1:      r_lum <= sh14;
            M_L2, M_L3: r_lum <= r_lum - sh14;
            M_L4:      r_lum <= r_lum + sh14;
            M_SCALE:   r_scale <= prod[31:0];
            M_PX_LO:   r_acc <= COL_BASE + ACC_W'(prod);
            M_PY_LO:   r_acc <= ROW_BASE + ACC_W'(prod);
            M_PX_HI, M_PY_HI:
                       r_acc <= r_acc + (ACC_W'(prod) <<< 16);
            M_ADDR:    r_addr <= AW'(prod) + AW'(r_col);
            M_RADDR:   r_addr <= AW'(prod) + AW'(r_in_col);
            default: ;
        endcase
    end

    always_comb begin
        ram_we    = i_cmd.clr_step || i_cmd.ram_wr_plot || i_cmd.ram_wr_clr;
        ram_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
        ram_wdata = i_cmd.ram_wr_plot ? {ooz, shade} : CLEAR_WORD;
    end

    zts_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_glyph;

endmodule

@@ hw/rtl/zbuffer_torus_point_shader.sv @@
// top level of the torus point shader: sequencer plus datapath
// depends on zts_pkg, zts_ctrl, zts_dp
//
// Usage: a plot transaction (kind 0) carries Q1.14 cosines and sines of the tube
// and ring angles; the point is rotated, projected and shaded, and if it is lit, in
// front and on the grid, the cell's depth and shade are updated if it is nearer.
// A plot gives no result. A read transaction (kind 1) returns the cell's glyph on
// the output channel and clears that cell; a cell outside the grid reads as a space.
// Configuration is written through the plain write port; the user must write it only
// while the block is idle, which the block itself does not enforce. Throughput: one
// transaction at a time. A plot holds the block through its micro-ops and checks,
// plus the 17-step bit-serial reciprocal when the depth is one or more; the 24x24
// multiplier is shared by every product, one per cycle. A read holds it until its
// glyph is loaded into a free output register; input ready returns as it becomes
// valid. Reset: the depth store is cleared one cell a cycle, all COLUMNS*ROWS cells
// (1760 by default), with input ready held low; configuration is taken meanwhile.
// Stall: the result sits in an output register; the block takes further plots
// while it waits, and a following read waits until the register is free.
module zbuffer_torus_point_shader
    import zts_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_cos_tube,
    input  logic signed [15:0] i_sin_tube,
    input  logic signed [15:0] i_cos_ring,
    input  logic signed [15:0] i_sin_ring,
    input  logic [6:0]         i_column,
    input  logic [4:0]         i_line,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_glyph
);

    t_cmd cmd;
    t_sts sts;

    zts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    zts_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cos_tube  (i_cos_tube),
        .i_sin_tube  (i_sin_tube),
        .i_cos_ring  (i_cos_ring),
        .i_sin_ring  (i_sin_ring),
        .i_column    (i_column),
        .i_line      (i_line),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_glyph     (o_glyph)
    );

endmodule

@@ hw/rtl/zts_checker.sv @@
// port-level checks for the torus point shader, bound to the top level
// depends on zbuffer_torus_point_shader_assert.svh
`include "zbuffer_torus_point_shader_assert.svh"

module zts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_glyph
);

    `ZTS_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ZTS_ASSERT_NEXT(a_glyph_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_glyph))
    // one transaction at a time
    `ZTS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ZTS_ASSERT_NOW(a_glyph_printable, i_clk, i_rst_n, o_out_valid, o_glyph >= 7'h20 && o_glyph <= 7'h7E)

endmodule

bind zbuffer_torus_point_shader zts_checker u_zts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_glyph     (o_glyph)
);
